[hw/rtl/cosine_tone_generator_top_defines.svh]
// ----------------------------------------------------------------------------
// Cosine tone generator assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef COSINE_TONE_GENERATOR_TOP_DEFINES_SVH
`define COSINE_TONE_GENERATOR_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define CTG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define CTG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/ctg_pkg.sv]
// ----------------------------------------------------------------------------
// Cosine tone generator package
// Shared widths, register map, reset values, CORDIC constants and types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ctg_pkg;

	// Parameter defaults
	localparam int PHASE_BITS_DEF    = 32;
	localparam int COS_FRAC_BITS_DEF = 15;

	// Field and register widths
	localparam int STEP_W     = 32;
	localparam int INDEX_W    = 32;
	localparam int AMP_W      = 15;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	// Register map
	localparam logic [CFG_IDX_W-1:0] REG_TONE_STEP   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_STEP = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO      = 8'd3;

	// Register reset values
	localparam logic [STEP_W-1:0] TONE_STEP_RST   = 32'd137438953;
	localparam logic [STEP_W-1:0] OFFSET_STEP_RST = 32'd53687091;
	localparam logic [AMP_W-1:0]  AMPLITUDE_RST   = 15'd1000;
	localparam logic              STEREO_RST      = 1'b0;

	// CORDIC rotator: Q2.30 datapath, angles in cycle * 2^32
	localparam int CORDIC_STEPS = 30;
	localparam int XW           = 33;
	localparam int ZW           = 33;
	localparam logic [31:0] CORDIC_X0 = 32'h26DD3B6A;

	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	// Control tag that travels alongside each sample through the pipeline
	typedef struct packed {
		logic valid;
		logic channel;
		logic last;
		logic flip;
	} tag_t;

	// One result word
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       channel;
		logic                       last;
	} res_t;

endpackage

`default_nettype wire

[hw/rtl/cosine_tone_generator_top.sv]
// An accepted index passes front registers s0 and s1, the CORDIC cells, post registers
// s1 and s2, then the output register. Throughput while not stalled: one index per cycle
// in mono; in stereo the next index waits while its right job issues, set by the single
// word per cycle of the 30-cell CORDIC chain. The whole chain stalls only when the output skid entry is occupied.
// Reset (arst_n low, asynchronous) empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
// Cosine tone generator top level
// DDS cosine oscillator: phase multiply, CORDIC cell chain, scaling, output skid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cosine_tone_generator_top_defines.svh"

module cosine_tone_generator_top #(
	parameter int PHASE_BITS    = ctg_pkg::PHASE_BITS_DEF,
	parameter int COS_FRAC_BITS = ctg_pkg::COS_FRAC_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// configuration
	input  wire                                   cfg_we,
	input  wire        [ctg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire        [ctg_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire        [ctg_pkg::INDEX_W-1:0]     sample_index,
	// output channel
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic signed [ctg_pkg::SAMPLE_W-1:0]   sample,
	output logic                                  channel,
	output logic                                  last
);

	localparam int N = ctg_pkg::CORDIC_STEPS;

	logic [ctg_pkg::STEP_W-1:0] tone_step_q;
	logic [ctg_pkg::STEP_W-1:0] offset_step_q;
	logic [ctg_pkg::AMP_W-1:0]  amplitude_q;
	logic                       stereo_q;

	logic                          adv;
	logic                          buf_full;
	logic signed [ctg_pkg::XW-1:0] x_c [0:N];
	logic signed [ctg_pkg::XW-1:0] y_c [0:N];
	logic signed [ctg_pkg::ZW-1:0] z_c [0:N];
	ctg_pkg::tag_t                 tag_c [0:N];
	logic                          res_valid;
	ctg_pkg::res_t                 res;
	ctg_pkg::res_t                 out_word;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_step_q   <= ctg_pkg::TONE_STEP_RST;
			offset_step_q <= ctg_pkg::OFFSET_STEP_RST;
			amplitude_q   <= ctg_pkg::AMPLITUDE_RST;
			stereo_q      <= ctg_pkg::STEREO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ctg_pkg::REG_TONE_STEP:   tone_step_q   <= cfg_data[ctg_pkg::STEP_W-1:0];
				ctg_pkg::REG_OFFSET_STEP: offset_step_q <= cfg_data[ctg_pkg::STEP_W-1:0];
				ctg_pkg::REG_AMPLITUDE:   amplitude_q   <= cfg_data[ctg_pkg::AMP_W-1:0];
				ctg_pkg::REG_STEREO:      stereo_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Whole chain moves together unless the skid entry holds a word
	assign adv = !buf_full;

	// Job issue and phase
	ctg_front #(
		.PHASE_BITS (PHASE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_index (sample_index),
		.tone_step    (tone_step_q),
		.offset_step  (offset_step_q),
		.stereo       (stereo_q),
		.z_out        (z_c[0]),
		.tag_out      (tag_c[0])
	);

	// Rotator start vector, gain compensated
	assign x_c[0] = ctg_pkg::XW'(ctg_pkg::CORDIC_X0);
	assign y_c[0] = '0;

	// CORDIC cell chain
	for (genvar i = 0; i < N; i++) begin : g_cell
		ctg_cordic_cell #(
			.SHIFT (i),
			.ATAN  (ctg_pkg::ATAN_TURNS[i])
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.x_in    (x_c[i]),
			.y_in    (y_c[i]),
			.z_in    (z_c[i]),
			.tag_in  (tag_c[i]),
			.x_out   (x_c[i+1]),
			.y_out   (y_c[i+1]),
			.z_out   (z_c[i+1]),
			.tag_out (tag_c[i+1])
		);
	end

	// Round, clamp, scale
	ctg_post #(
		.COS_FRAC_BITS (COS_FRAC_BITS)
	) u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.x_in      (x_c[N]),
		.tag_in    (tag_c[N]),
		.amplitude (amplitude_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register and skid
	ctg_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid && adv),
		.push_word (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	assign sample  = out_word.sample;
	assign channel = out_word.channel;
	assign last    = out_word.last;

	// Checks
	`CTG_ASSERT_SAME(a_full_has_out, buf_full, out_valid, "skid word held with output empty")
	`CTG_ASSERT_NEXT(a_stereo_holds_in, in_valid && !in_stall && stereo_q, in_stall, "stereo right half not reserved")
	`CTG_ASSERT_NEXT(a_right_follows, out_valid && !out_stall && !last, out_valid && channel, "right word missing after left")

endmodule

`default_nettype wire

[hw/rtl/ctg_front.sv]
// ----------------------------------------------------------------------------
// Cosine tone generator front end
// Takes input words, issues one or two phase jobs and forms the folded angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctg_front #(
	parameter int PHASE_BITS = ctg_pkg::PHASE_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               adv,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire        [ctg_pkg::INDEX_W-1:0] sample_index,
	input  wire        [ctg_pkg::STEP_W-1:0]  tone_step,
	input  wire        [ctg_pkg::STEP_W-1:0]  offset_step,
	input  wire                               stereo,
	output logic signed [ctg_pkg::ZW-1:0]     z_out,
	output ctg_pkg::tag_t                     tag_out
);

	localparam int PH_W = (PHASE_BITS < 32) ? PHASE_BITS : 32;

	logic                          pend_q;
	logic                          accept;
	logic                          job_valid;
	logic [ctg_pkg::INDEX_W-1:0]   job_idx;
	logic [ctg_pkg::STEP_W-1:0]    job_step;
	ctg_pkg::tag_t                 job_tag;

	logic [ctg_pkg::INDEX_W-1:0]   idx_s0;
	logic [ctg_pkg::STEP_W-1:0]    step_s0;
	ctg_pkg::tag_t                 tag_s0;
	logic [31:0]                   prod;

	logic [PH_W-1:0]               ph_s1;
	ctg_pkg::tag_t                 tag_s1;
	logic [31:0]                   ang;
	logic                          flip;
	logic [31:0]                   ang_fold;

	// Hold off the next word while the chain is stalled or the right half of a stereo pair is due
	assign in_stall = !adv || pend_q;
	assign accept   = in_valid && !in_stall;

	// Job select: right half reuses the index already in stage 0
	always_comb begin
		job_valid       = accept || pend_q;
		job_idx         = pend_q ? idx_s0 : sample_index;
		if (pend_q) begin
			job_step = tone_step - offset_step;
		end else if (stereo) begin
			job_step = tone_step + offset_step;
		end else begin
			job_step = tone_step;
		end
		job_tag.valid   = job_valid;
		job_tag.channel = pend_q;
		job_tag.last    = pend_q || !stereo;
		job_tag.flip    = 1'b0;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			tag_s0 <= '0;
			tag_s1 <= '0;
		end else if (adv) begin
			pend_q <= accept && stereo;
			tag_s0 <= job_tag;
			tag_s1 <= tag_s0;
		end
	end

	// Phase = index * step, modulo one cycle
	assign prod = idx_s0 * step_s0;

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s0  <= job_idx;
			step_s0 <= job_step;
			ph_s1   <= prod[31 -: PH_W];
		end
	end

	// Fold into a quarter cycle either side of zero, flipping the sign outside it
	always_comb begin
		ang      = 32'(ph_s1) << (32 - PH_W);
		flip     = ang[31] ^ ang[30];
		ang_fold = {ang[31] ^ flip, ang[30:0]};
	end

	assign z_out = ctg_pkg::ZW'($signed(ang_fold));

	always_comb begin
		tag_out      = tag_s1;
		tag_out.flip = flip;
	end

endmodule

`default_nettype wire

[hw/rtl/ctg_cordic_cell.sv]
// ----------------------------------------------------------------------------
// Cosine tone generator CORDIC cell
// One registered rotation step of the cosine rotator chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctg_cordic_cell #(
	parameter int          SHIFT = 0,
	parameter logic [31:0] ATAN  = ctg_pkg::ATAN_TURNS[0]
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            adv,
	input  wire signed  [ctg_pkg::XW-1:0]  x_in,
	input  wire signed  [ctg_pkg::XW-1:0]  y_in,
	input  wire signed  [ctg_pkg::ZW-1:0]  z_in,
	input  ctg_pkg::tag_t                  tag_in,
	output logic signed [ctg_pkg::XW-1:0]  x_out,
	output logic signed [ctg_pkg::XW-1:0]  y_out,
	output logic signed [ctg_pkg::ZW-1:0]  z_out,
	output ctg_pkg::tag_t                  tag_out
);

	localparam logic signed [ctg_pkg::ZW-1:0] ATAN_Z = ctg_pkg::ZW'(ATAN);

	logic signed [ctg_pkg::XW-1:0] dx;
	logic signed [ctg_pkg::XW-1:0] dy;
	logic signed [ctg_pkg::XW-1:0] x_nxt;
	logic signed [ctg_pkg::XW-1:0] y_nxt;
	logic signed [ctg_pkg::ZW-1:0] z_nxt;

	logic signed [ctg_pkg::XW-1:0] x_s1;
	logic signed [ctg_pkg::XW-1:0] y_s1;
	logic signed [ctg_pkg::ZW-1:0] z_s1;
	ctg_pkg::tag_t                 tag_s1;

	// Rotate towards zero residual angle; floor shifts
	always_comb begin
		dx = y_in >>> SHIFT;
		dy = x_in >>> SHIFT;
		if (!z_in[ctg_pkg::ZW-1]) begin
			x_nxt = x_in - dx;
			y_nxt = y_in + dy;
			z_nxt = z_in - ATAN_Z;
		end else begin
			x_nxt = x_in + dx;
			y_nxt = y_in - dy;
			z_nxt = z_in + ATAN_Z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1 <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= x_nxt;
			y_s1 <= y_nxt;
			z_s1 <= z_nxt;
		end
	end

	assign x_out   = x_s1;
	assign y_out   = y_s1;
	assign z_out   = z_s1;
	assign tag_out = tag_s1;

endmodule

`default_nettype wire

[hw/rtl/ctg_post.sv]
// ----------------------------------------------------------------------------
// Cosine tone generator post-processing
// Rounds and clamps the cosine, scales it by the amplitude, applies the sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctg_post #(
	parameter int COS_FRAC_BITS = ctg_pkg::COS_FRAC_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            adv,
	input  wire signed  [ctg_pkg::XW-1:0]  x_in,
	input  ctg_pkg::tag_t                  tag_in,
	input  wire         [ctg_pkg::AMP_W-1:0] amplitude,
	output logic                           res_valid,
	output ctg_pkg::res_t                  res
);

	localparam int CF  = COS_FRAC_BITS;
	localparam int XW  = ctg_pkg::XW;
	localparam int SH  = 30 - CF;
	localparam logic [XW-1:0] RND = XW'(1) << (29 - CF);
	localparam logic [XW-1:0] LIM = XW'(1) << CF;
	localparam int PW  = CF + 1 + ctg_pkg::AMP_W;

	logic signed [XW-1:0]             x_rnd;
	logic signed [XW-1:0]             x_sh;
	logic signed [XW-1:0]             x_abs;
	logic                             x_neg;
	logic        [CF:0]               mag;
	logic        [PW-1:0]             prod;

	logic        [CF:0]               mag_s1;
	logic                             neg_s1;
	ctg_pkg::tag_t                    tag_s1;
	logic        [ctg_pkg::SAMPLE_W-1:0] mag_s2;
	logic                             neg_s2;
	ctg_pkg::tag_t                    tag_s2;

	// Round half up, take magnitude, clamp to one
	always_comb begin
		x_rnd = x_in + $signed(RND);
		x_sh  = x_rnd >>> SH;
		x_neg = x_sh[XW-1];
		x_abs = x_neg ? -x_sh : x_sh;
		if (x_abs > $signed(LIM)) begin
			mag = (CF+1)'(LIM);
		end else begin
			mag = (CF+1)'(x_abs);
		end
	end

	// Scale by amplitude, truncating the magnitude
	assign prod = PW'(mag_s1) * PW'(amplitude);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (adv) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= mag;
			neg_s1 <= x_neg ^ tag_in.flip;
			mag_s2 <= prod[CF +: ctg_pkg::SAMPLE_W];
			neg_s2 <= neg_s1;
		end
	end

	// Sign back on, two's complement
	always_comb begin
		res_valid   = tag_s2.valid;
		res.sample  = neg_s2 ? $signed(ctg_pkg::SAMPLE_W'(0) - mag_s2) : $signed(mag_s2);
		res.channel = tag_s2.channel;
		res.last    = tag_s2.last;
	end

endmodule

`default_nettype wire

[hw/rtl/ctg_out_buf.sv]
// ----------------------------------------------------------------------------
// Cosine tone generator output buffer
// Output register plus skid entry; full flag is registered to freeze the chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctg_out_buf (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  ctg_pkg::res_t  push_word,
	output logic           full,
	output logic           out_valid,
	input  wire            out_stall,
	output ctg_pkg::res_t  out_word
);

	logic          o_valid_q;
	logic          k_valid_q;
	ctg_pkg::res_t o_word_q;
	ctg_pkg::res_t k_word_q;
	logic          o_free;

	// Output register free when empty or being taken
	assign o_free = !o_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			k_valid_q <= 1'b0;
		end else begin
			if (o_free) begin
				o_valid_q <= k_valid_q || push;
				k_valid_q <= 1'b0;
			end else if (push) begin
				k_valid_q <= 1'b1;
			end
		end
	end

	// Skid word drains first; a push never meets a full skid entry
	always_ff @(posedge clk) begin
		if (o_free) begin
			o_word_q <= k_valid_q ? k_word_q : push_word;
		end
		if (!o_free && push) begin
			k_word_q <= push_word;
		end
	end

	assign full      = k_valid_q;
	assign out_valid = o_valid_q;
	assign out_word  = o_word_q;

endmodule

`default_nettype wire
